// ===== sv/espt_pkg.sv =====
`timescale 1ns / 1ps
package espt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int TICK_W        = 16;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd300;

    typedef enum logic [1:0] {
        OP_OUTBOUND = 2'd0,
        OP_INBOUND  = 2'd1,
        OP_TICK     = 2'd2,
        OP_UNUSED   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        OC_ADDED     = 3'd0,
        OC_PAIRED    = 3'd1,
        OC_FOUND     = 3'd2,
        OC_NOT_FOUND = 3'd3,
        OC_FULL      = 3'd4,
        OC_TICK_DONE = 3'd5,
        OC_PAIR_ADD  = 3'd6
    } outcome_t;

    typedef enum logic [1:0] {
        DIR_ORIGINAL = 2'd0,
        DIR_REPLY    = 2'd1,
        DIR_NONE     = 2'd2
    } dir_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] spi;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
    } req_t;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [1:0]  direction;
        logic [31:0] tuple_src_spi;
        logic [31:0] tuple_dst_spi;
        logic [31:0] peer_src_ip;
        logic [31:0] peer_dst_ip;
        logic        accept;
    } res_t;

    typedef struct packed {
        logic              valid;
        logic [31:0]       src_ip;
        logic [31:0]       dst_ip;
        logic [31:0]       src_spi;
        logic [31:0]       peer_spi;
        logic [TICK_W-1:0] ticks;
    } entry_t;

    // broadcast to every cell
    typedef struct packed {
        logic              age;
        logic              shift;
        logic [31:0]       key_spi;
        logic [31:0]       key_pend;
        logic [31:0]       new_src_ip;
        logic [31:0]       new_dst_ip;
        logic [31:0]       new_spi;
        logic [31:0]       peer_val;
        logic [TICK_W-1:0] timeout;
    } cell_bus_t;

    typedef struct packed {
        logic load;
        logic refresh;
        logic set_peer;
    } cell_ctl_t;

    typedef struct packed {
        logic spi_src;
        logic spi_peer;
        logic pend_src;
        logic pend_peer;
    } cell_hit_t;

endpackage

// ===== sv/espt_cell.sv =====
`timescale 1ns / 1ps
module espt_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  espt_pkg::cell_bus_t bus,
    input  espt_pkg::cell_ctl_t ctl,
    input  espt_pkg::entry_t    nxt,
    input  logic                hole_in,
    output espt_pkg::entry_t    ent,
    output logic                hole_out,
    output espt_pkg::cell_hit_t hit
);

    logic                      valid_reg;
    logic                      valid_next;
    espt_pkg::entry_t          data_reg;
    espt_pkg::entry_t          data_next;

    always_comb
    begin
        ent       = data_reg;
        ent.valid = valid_reg;
    end

    assign hole_out      = hole_in | ~valid_reg;
    assign hit.spi_src   = valid_reg && (data_reg.src_spi == bus.key_spi);
    assign hit.spi_peer  = valid_reg && (data_reg.peer_spi == bus.key_spi);
    assign hit.pend_src  = valid_reg && (data_reg.src_spi == bus.key_pend);
    assign hit.pend_peer = valid_reg && (data_reg.peer_spi == bus.key_pend);

    always_comb
    begin
        data_next  = ent;
        valid_next = valid_reg;
        if (bus.shift)
        begin
            if (hole_out)
            begin
                data_next  = nxt;
                valid_next = nxt.valid;
            end
        end
        else if (bus.age)
        begin
            data_next.ticks = data_reg.ticks - espt_pkg::TICK_W'(1);
            valid_next      = valid_reg && (data_reg.ticks > espt_pkg::TICK_W'(1));
        end
        else
        begin
            if (ctl.load)
            begin
                valid_next         = 1'b1;
                data_next.src_ip   = bus.new_src_ip;
                data_next.dst_ip   = bus.new_dst_ip;
                data_next.src_spi  = bus.new_spi;
                data_next.peer_spi = '0;
                data_next.ticks    = bus.timeout;
            end
            if (ctl.refresh)
            begin
                data_next.ticks = bus.timeout;
            end
            if (ctl.set_peer)
            begin
                data_next.peer_spi = bus.peer_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== sv/esp_spi_pairing_table_core.sv =====
`timescale 1ns / 1ps
// esp spi pairing table, built as a row of entry cells
// request channel: req_valid / req_ready / req_data (operation, spi, src_ip, dst_ip)
// result channel:  res_valid / res_ready / res_data, one result per request
// config: cfg_we / cfg_wdata write the entry lifetime in ticks (reset 300)
// one request is worked on at a time; req_ready is high only when the block is idle
// lookup and query: a compare state (every cell compares), then an update state whose result is registered
// timer tick: an aging state, then the cells hand entries
//   down the row one step per cycle to close the gaps left by expired entries
// the compare cycle is set by the per-cell spi comparators and the oldest-match pick
// the result sits in an output register; the next request is taken while it waits
// if the receiver stalls and the register is still full, the finished result is
//   held and no new request is taken until the register frees
// reset empties the table, clears the pending spi and loads the default lifetime
module esp_spi_pairing_table_core #(
    parameter int TABLE_ENTRIES = espt_pkg::TABLE_ENTRIES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  espt_pkg::req_t                  req_data,
    output logic                            res_valid,
    input  logic                            res_ready,
    output espt_pkg::res_t                  res_data,
    input  logic                            cfg_we,
    input  logic [espt_pkg::TICK_W-1:0]     cfg_wdata
);

    localparam int CNT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES - 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_LOOK  = 6'b000010,
        ST_UPD   = 6'b000100,
        ST_AGE   = 6'b001000,
        ST_SHIFT = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    state_t                          state_reg, state_next;
    espt_pkg::req_t                  req_reg;
    logic [espt_pkg::TICK_W-1:0]     timeout_reg;
    logic [31:0]                     pend_reg, pend_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic                            res_valid_reg;
    espt_pkg::res_t                  res_data_reg;
    espt_pkg::res_t                  hold_reg, hold_next;
    espt_pkg::res_t                  res_calc;
    logic                            done;

    espt_pkg::cell_bus_t             bus;
    espt_pkg::cell_ctl_t             ctl     [TABLE_ENTRIES];
    espt_pkg::entry_t                ent     [TABLE_ENTRIES];
    espt_pkg::entry_t                nxt     [TABLE_ENTRIES];
    espt_pkg::cell_hit_t             hit     [TABLE_ENTRIES];
    logic [TABLE_ENTRIES:0]          hole;
    logic [TABLE_ENTRIES-1:0]        vld_vec;

    // look-up results
    logic [TABLE_ENTRIES-1:0]        f_sel_reg, f_sel_next, g_sel_reg, g_sel_next;
    logic                            f_found_reg, f_found_next, g_found_reg, g_found_next;
    logic                            f_rep_reg, f_rep_next, g_rep_reg, g_rep_next;
    espt_pkg::entry_t                f_ent_reg, f_ent_next, g_ent_reg, g_ent_next;

    logic [TABLE_ENTRIES-1:0]        free_sel, load_vec, refresh_vec, peer_vec;
    logic                            peer_pend;
    logic                            full;
    logic                            out_free;

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;
    assign out_free  = !res_valid_reg || res_ready;
    assign hole[0]   = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++)
        begin : g_cell
            if (gi == TABLE_ENTRIES - 1)
            begin : g_end
                assign nxt[gi] = '0;
            end
            else
            begin : g_mid
                assign nxt[gi] = ent[gi+1];
            end
            assign ctl[gi].load     = load_vec[gi];
            assign ctl[gi].refresh  = refresh_vec[gi];
            assign ctl[gi].set_peer = peer_vec[gi];
            assign vld_vec[gi]      = ent[gi].valid;
            espt_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .bus      (bus),
                .ctl      (ctl[gi]),
                .nxt      (nxt[gi]),
                .hole_in  (hole[gi]),
                .ent      (ent[gi]),
                .hole_out (hole[gi+1]),
                .hit      (hit[gi])
            );
        end
    endgenerate

    always_comb
    begin
        bus.age        = (state_reg == ST_AGE);
        bus.shift      = (state_reg == ST_SHIFT);
        bus.key_spi    = req_reg.spi;
        bus.key_pend   = pend_reg;
        bus.new_src_ip = req_reg.src_ip;
        bus.new_dst_ip = req_reg.dst_ip;
        bus.new_spi    = req_reg.spi;
        bus.peer_val   = peer_pend ? pend_reg : req_reg.spi;
        bus.timeout    = timeout_reg;
    end

    // oldest match for the packet spi and for the pending spi
    always_comb
    begin
        logic f_seen;
        logic g_seen;
        f_seen       = 1'b0;
        g_seen       = 1'b0;
        f_sel_next   = '0;
        g_sel_next   = '0;
        f_rep_next   = 1'b0;
        g_rep_next   = 1'b0;
        f_ent_next   = '0;
        g_ent_next   = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (!f_seen && (hit[i].spi_src || hit[i].spi_peer))
            begin
                f_sel_next[i] = 1'b1;
                f_rep_next    = !hit[i].spi_src;
                f_ent_next    = ent[i];
            end
            if (!g_seen && (hit[i].pend_src || hit[i].pend_peer))
            begin
                g_sel_next[i] = 1'b1;
                g_rep_next    = !hit[i].pend_src;
                g_ent_next    = ent[i];
            end
            f_seen = f_seen | hit[i].spi_src | hit[i].spi_peer;
            g_seen = g_seen | hit[i].pend_src | hit[i].pend_peer;
        end
        f_found_next = f_seen;
        g_found_next = g_seen;
    end

    always_comb
    begin
        free_sel = ~vld_vec & ((vld_vec << 1) | TABLE_ENTRIES'(1));
        full     = vld_vec[TABLE_ENTRIES-1];
    end

    always_comb
    begin
        res_calc      = '0;
        res_calc.outcome   = espt_pkg::OC_NOT_FOUND;
        res_calc.direction = espt_pkg::DIR_NONE;
        res_calc.accept    = 1'b1;
        pend_next     = pend_reg;
        load_vec      = '0;
        refresh_vec   = '0;
        peer_vec      = '0;
        peer_pend     = 1'b0;
        if (state_reg == ST_UPD)
        begin
            case (req_reg.operation)
                espt_pkg::OP_OUTBOUND:
                begin
                    if (!f_found_reg)
                    begin
                        if (pend_reg == '0)
                        begin
                            load_vec              = free_sel;
                            pend_next             = req_reg.spi;
                            res_calc.outcome      = full ? espt_pkg::OC_FULL : espt_pkg::OC_ADDED;
                            res_calc.direction    = espt_pkg::DIR_ORIGINAL;
                            res_calc.tuple_src_spi = req_reg.spi;
                        end
                        else if (g_found_reg)
                        begin
                            refresh_vec = g_sel_reg;
                            peer_vec    = g_sel_reg;
                            if (g_ent_reg.dst_ip == req_reg.dst_ip)
                            begin
                                peer_pend              = 1'b1;
                                load_vec               = free_sel;
                                pend_next              = req_reg.spi;
                                res_calc.outcome       = full ? espt_pkg::OC_FULL
                                                              : espt_pkg::OC_PAIR_ADD;
                                res_calc.direction     = espt_pkg::DIR_ORIGINAL;
                                res_calc.tuple_src_spi = req_reg.spi;
                            end
                            else
                            begin
                                pend_next              = '0;
                                res_calc.outcome       = espt_pkg::OC_PAIRED;
                                res_calc.direction     = g_rep_reg ? espt_pkg::DIR_REPLY
                                                                   : espt_pkg::DIR_ORIGINAL;
                                res_calc.tuple_dst_spi = pend_reg;
                            end
                        end
                    end
                    else
                    begin
                        refresh_vec        = f_sel_reg;
                        res_calc.direction = f_rep_reg ? espt_pkg::DIR_REPLY
                                                       : espt_pkg::DIR_ORIGINAL;
                        if (pend_reg == req_reg.spi && f_ent_reg.src_ip != req_reg.src_ip)
                        begin
                            peer_vec               = f_sel_reg;
                            pend_next              = '0;
                            res_calc.outcome       = espt_pkg::OC_PAIRED;
                            res_calc.tuple_dst_spi = pend_reg;
                        end
                        else
                        begin
                            res_calc.outcome       = espt_pkg::OC_FOUND;
                            res_calc.tuple_src_spi = f_rep_reg ? f_ent_reg.peer_spi
                                                               : f_ent_reg.src_spi;
                            res_calc.tuple_dst_spi = f_rep_reg ? f_ent_reg.src_spi
                                                               : f_ent_reg.peer_spi;
                        end
                    end
                end
                espt_pkg::OP_INBOUND:
                begin
                    if (f_found_reg)
                    begin
                        refresh_vec          = f_sel_reg;
                        res_calc.outcome     = espt_pkg::OC_FOUND;
                        res_calc.direction   = f_rep_reg ? espt_pkg::DIR_REPLY
                                                         : espt_pkg::DIR_ORIGINAL;
                        res_calc.peer_src_ip = f_ent_reg.src_ip;
                        res_calc.peer_dst_ip = f_ent_reg.dst_ip;
                    end
                    else
                    begin
                        res_calc.accept = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == ST_SHIFT)
        begin
            res_calc.outcome = espt_pkg::OC_TICK_DONE;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        hold_next  = hold_reg;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_data.operation == espt_pkg::OP_TICK)
                    begin
                        state_next = ST_AGE;
                    end
                    else
                    begin
                        state_next = ST_LOOK;
                    end
                end
            end
            ST_LOOK:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                done = 1'b1;
            end
            ST_AGE:
            begin
                cnt_next   = '0;
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                done     = (cnt_reg == CNT_LAST);
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (done)
        begin
            hold_next  = res_calc;
            state_next = out_free ? ST_IDLE : ST_FIN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            timeout_reg   <= espt_pkg::TIMEOUT_RESET;
            pend_reg      <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            cnt_reg   <= cnt_next;
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            if ((done || state_reg == ST_FIN) && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        if (req_valid && req_ready)
        begin
            req_reg <= req_data;
        end
        if (state_reg == ST_LOOK)
        begin
            f_sel_reg   <= f_sel_next;
            g_sel_reg   <= g_sel_next;
            f_found_reg <= f_found_next;
            g_found_reg <= g_found_next;
            f_rep_reg   <= f_rep_next;
            g_rep_reg   <= g_rep_next;
            f_ent_reg   <= f_ent_next;
            g_ent_reg   <= g_ent_next;
        end
        if (done && out_free)
        begin
            res_data_reg <= res_calc;
        end
        else if (state_reg == ST_FIN && out_free)
        begin
            res_data_reg <= hold_reg;
        end
    end

    // valid entries always form a prefix while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> ((vld_vec >> 1) & ~vld_vec) == '0)
        else $error("table has a gap while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(peer_vec) && $onehot0(load_vec))
        else $error("more than one cell written");

    assert property (@(posedge clk) disable iff (!rst_n)
        (load_vec & vld_vec) == '0)
        else $error("new entry overwrites a valid cell");

    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> state_reg != ST_IDLE)
        else $error("accepted request not started");

endmodule
